[rtl/slt_pkg.sv]
// slt_pkg: shared types, character codes and result kinds for the shell line tokenizer
// no dependencies; used by every module of the block

package slt_pkg;

	// result kinds
	localparam logic [2:0] KIND_LETTER = 3'd0;
	localparam logic [2:0] KIND_WEND   = 3'd1;
	localparam logic [2:0] KIND_OP     = 3'd2;
	localparam logic [2:0] KIND_LINE   = 3'd3;
	localparam logic [2:0] KIND_REJECT = 3'd4;

	// scan modes (code 3 is unused and acts as in a word)
	localparam logic [1:0] MODE_BETWEEN = 2'd0;
	localparam logic [1:0] MODE_WORD    = 2'd1;
	localparam logic [1:0] MODE_QUOTE   = 2'd2;

	// held operator codes
	localparam logic [1:0] PEND_AMP = 2'd0;
	localparam logic [1:0] PEND_BAR = 2'd1;
	localparam logic [1:0] PEND_GT  = 2'd2;

	// character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_BAR   = 8'h7C;

	// one result word
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] value;
		logic       double_op;
	} result_t;

	// all results of one input byte: one, or two when two is set
	typedef struct packed {
		logic    two;
		result_t r0;
		result_t r1;
	} entry_t;

	// character of a held operator
	function automatic logic [7:0] pend_char(input logic [1:0] code);
		logic [7:0] ch;
		case (code)
			PEND_BAR: ch = CH_BAR;
			PEND_GT:  ch = CH_GT;
			default:  ch = CH_AMP;
		endcase
		return ch;
	endfunction

endpackage

[rtl/slt_front.sv]
// slt_front: accepts input bytes, runs the lexer state and forms the results of each byte
// depends on slt_pkg; feeds slt_fifo

module slt_front import slt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] byte_in,
	input  logic       q_full,
	output logic       push,
	output entry_t     entry
);

	logic [1:0] mode_q;
	logic       has_q;
	logic       pend_v_q;
	logic [1:0] pend_op_q;
	logic       rest_q;

	logic [1:0] mode_d;
	logic       has_d;
	logic       pend_v_d;
	logic [1:0] pend_op_d;
	logic       rest_d;

	result_t    res [2];
	logic [1:0] cnt;
	logic       done;
	logic [7:0] pch;
	logic       accept;
	logic       is_letter;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// plain word letter: no separator, operator, quote, nul or newline
	assign is_letter = (byte_in != CH_NL)    && (byte_in != CH_NUL)  &&
	                   (byte_in != CH_SPACE) && (byte_in != CH_TAB)  &&
	                   (byte_in != CH_AMP)   && (byte_in != CH_BAR)  &&
	                   (byte_in != CH_GT)    && (byte_in != CH_LPAR) &&
	                   (byte_in != CH_RPAR)  && (byte_in != CH_SEMI) &&
	                   (byte_in != CH_LT)    && (byte_in != CH_QUOTE);

	// lexer step: next state and up to two results
	always_comb begin
		mode_d    = mode_q;
		has_d     = has_q;
		pend_v_d  = pend_v_q;
		pend_op_d = pend_op_q;
		rest_d    = rest_q;
		res[0]    = '0;
		res[1]    = '0;
		cnt       = 2'd0;
		done      = 1'b0;
		pch       = pend_char(pend_op_q);

		if (rest_q) begin
			// rest of the line ignored, only quotes still counted
			if (byte_in == CH_NL) begin
				res[cnt[0]].kind = (mode_q == MODE_QUOTE) ? KIND_REJECT : KIND_LINE;
				cnt       = cnt + 2'd1;
				mode_d    = MODE_BETWEEN;
				has_d     = 1'b0;
				pend_v_d  = 1'b0;
				pend_op_d = PEND_AMP;
				rest_d    = 1'b0;
			end else if (byte_in == CH_QUOTE) begin
				mode_d = (mode_q == MODE_QUOTE) ? MODE_BETWEEN : MODE_QUOTE;
			end
		end else if (mode_q == MODE_QUOTE) begin
			// inside quotes every byte but quote and newline is a letter
			if (byte_in == CH_NL) begin
				res[cnt[0]].kind = KIND_REJECT;
				cnt       = cnt + 2'd1;
				mode_d    = MODE_BETWEEN;
				has_d     = 1'b0;
				pend_v_d  = 1'b0;
				pend_op_d = PEND_AMP;
			end else if (byte_in == CH_QUOTE) begin
				mode_d = MODE_WORD;
			end else begin
				res[cnt[0]].kind  = KIND_LETTER;
				res[cnt[0]].value = byte_in;
				cnt   = cnt + 2'd1;
				has_d = 1'b1;
			end
		end else begin
			// resolve a held operator against this byte
			if (pend_v_q) begin
				pend_v_d  = 1'b0;
				pend_op_d = PEND_AMP;
				res[cnt[0]].kind  = KIND_OP;
				res[cnt[0]].value = pch;
				if (byte_in == pch) begin
					res[cnt[0]].double_op = 1'b1;
					done = 1'b1;
				end
				cnt = cnt + 2'd1;
			end
			if (!done) begin
				if (is_letter) begin
					// word letter
					res[cnt[0]].kind  = KIND_LETTER;
					res[cnt[0]].value = byte_in;
					cnt    = cnt + 2'd1;
					has_d  = 1'b1;
					mode_d = MODE_WORD;
				end else if (byte_in == CH_QUOTE) begin
					mode_d = MODE_QUOTE;
				end else begin
					// every other class closes the open word first
					if (has_q) begin
						res[cnt[0]].kind = KIND_WEND;
						cnt = cnt + 2'd1;
					end
					has_d  = 1'b0;
					mode_d = MODE_BETWEEN;
					if (byte_in == CH_NL) begin
						res[cnt[0]].kind = KIND_LINE;
						cnt       = cnt + 2'd1;
						pend_v_d  = 1'b0;
						pend_op_d = PEND_AMP;
					end else if (byte_in == CH_NUL) begin
						rest_d = 1'b1;
					end else if (byte_in == CH_AMP) begin
						pend_v_d  = 1'b1;
						pend_op_d = PEND_AMP;
					end else if (byte_in == CH_BAR) begin
						pend_v_d  = 1'b1;
						pend_op_d = PEND_BAR;
					end else if (byte_in == CH_GT) begin
						pend_v_d  = 1'b1;
						pend_op_d = PEND_GT;
					end else if (byte_in == CH_LPAR || byte_in == CH_RPAR ||
					             byte_in == CH_SEMI || byte_in == CH_LT) begin
						res[cnt[0]].kind  = KIND_OP;
						res[cnt[0]].value = byte_in;
						cnt = cnt + 2'd1;
					end
				end
			end
		end
	end

	// queue write
	assign push     = accept && (cnt != 2'd0);
	assign entry.two = cnt[1];
	assign entry.r0  = res[0];
	assign entry.r1  = res[1];

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_BETWEEN;
			has_q     <= 1'b0;
			pend_v_q  <= 1'b0;
			pend_op_q <= PEND_AMP;
			rest_q    <= 1'b0;
		end else if (accept) begin
			mode_q    <= mode_d;
			has_q     <= has_d;
			pend_v_q  <= pend_v_d;
			pend_op_q <= pend_op_d;
			rest_q    <= rest_d;
		end
	end

	// a held operator always follows a closed word
	a_pend_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> !has_q)
		else $error("held operator while a word is open");

endmodule

[rtl/slt_fifo.sv]
// slt_fifo: short queue of result entries between the front and back parts
// depends on slt_pkg for the entry type

module slt_fifo import slt_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wdata,
	output logic   full,
	input  logic   pop,
	output entry_t rdata,
	output logic   empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

endmodule

[rtl/slt_back.sv]
// slt_back: takes queue entries and hands out one result word per cycle unless stalled
// depends on slt_pkg; fed by slt_fifo

module slt_back import slt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  entry_t     q_data,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] kind,
	output logic [7:0] value,
	output logic       double_op,
	output logic       last
);

	entry_t  cur_q;
	logic    cur_v_q;
	logic    idx_q;
	result_t sel;
	logic    taken;
	logic    finish;

	assign sel       = idx_q ? cur_q.r1 : cur_q.r0;
	assign out_valid = cur_v_q;
	assign kind      = sel.kind;
	assign value     = sel.value;
	assign double_op = sel.double_op;
	assign last      = idx_q || !cur_q.two;

	assign taken  = cur_v_q && !out_stall;
	assign finish = taken && last;
	assign pop    = !q_empty && (!cur_v_q || finish);

	// current entry payload
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_data;
		end
	end

	// output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			idx_q   <= 1'b0;
		end else if (pop) begin
			cur_v_q <= 1'b1;
			idx_q   <= 1'b0;
		end else if (finish) begin
			cur_v_q <= 1'b0;
			idx_q   <= 1'b0;
		end else if (taken) begin
			idx_q <= 1'b1;
		end
	end

	a_second_only_if_two: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_v_q && idx_q) |-> cur_q.two)
		else $error("second result shown for a one-result entry");

	a_first_then_second: assert property (@(posedge clk) disable iff (!arst_n)
		(taken && !last) |=> (cur_v_q && idx_q))
		else $error("second result of an entry lost");

endmodule

[rtl/shell_line_tokenizer.sv]
// shell_line_tokenizer: streaming command line lexer, one byte in per cycle unless stalled
// throughput: one byte per cycle in while in_stall is low, one result word per cycle out
// while out_stall is low; a byte with two results holds the output for both of its words,
// and the result queue absorbs the difference
// reset: arst_n clears the lexer state, the queue and the output register
// depends on slt_pkg, slt_front, slt_fifo, slt_back

module shell_line_tokenizer import slt_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] byte_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] kind,
	output logic [7:0] value,
	output logic       double_op,
	output logic       last
);

	logic   q_full;
	logic   q_empty;
	logic   push;
	logic   pop;
	entry_t wr_entry;
	entry_t rd_entry;

	// front: classify bytes and form results
	slt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.byte_in  (byte_in),
		.q_full   (q_full),
		.push     (push),
		.entry    (wr_entry)
	);

	// queue between front and back
	slt_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wr_entry),
		.full   (q_full),
		.pop    (pop),
		.rdata  (rd_entry),
		.empty  (q_empty)
	);

	// back: serialize results onto the output channel
	slt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (rd_entry),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.value     (value),
		.double_op (double_op),
		.last      (last)
	);

endmodule
